// File: src/eot_pkg.sv
// ----------------------------------------------------------------------------
// eot_pkg
// Shared types and constants for the exon offset translator: table depth,
// index widths, opcodes, status codes and the walker interface structs.
// ----------------------------------------------------------------------------
package eot_pkg;

   localparam int MAX_EXONS = 64;
   localparam int IDX_W     = $clog2(MAX_EXONS);
   localparam int CNT_W     = $clog2(MAX_EXONS + 1);
   localparam int POS_W     = 32;
   localparam int ENTRY_W   = 2 * POS_W;

   typedef enum logic [1:0] {
      OP_CLEAR     = 2'd0,
      OP_APPEND    = 2'd1,
      OP_TO_CODING = 2'd2,
      OP_TO_CONTIG = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_ORDER     = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

   typedef struct packed {
      logic             go;
      logic             to_coding;
      logic             reverse;
      logic [POS_W-1:0] position;
      logic [CNT_W-1:0] count;
   } walk_cmd_type;

   typedef struct packed {
      logic             done;
      logic             found;
      logic [POS_W-1:0] mapped;
      logic [POS_W-1:0] total;
   } walk_result_type;

endpackage

// File: src/eot_ram.sv
// ----------------------------------------------------------------------------
// eot_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module eot_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/eot_walk.sv
// ----------------------------------------------------------------------------
// eot_walk
// Query sequencer: walks the stored exons one per cycle in strand order,
// running a shared compare/subtract/accumulate unit on each interval.
// ----------------------------------------------------------------------------
module eot_walk (
   input  logic                        clock,
   input  logic                        reset,
   input  eot_pkg::walk_cmd_type       cmd,
   output logic [eot_pkg::IDX_W-1:0]   rd_addr,
   input  logic [eot_pkg::ENTRY_W-1:0] rd_data,
   output logic                        busy,
   output eot_pkg::walk_result_type    result
);

   import eot_pkg::*;

   typedef enum logic {
      WS_IDLE,
      WS_RUN
   } walk_state_type;

   walk_state_type   state_ff, state_in;
   logic             pv_ff, pv_in;
   logic [CNT_W-1:0] ik_ff, ik_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             to_coding_ff, to_coding_in;
   logic             reverse_ff, reverse_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] acc_ff, acc_in;
   logic [POS_W-1:0] total_ff, total_in;
   logic [POS_W-1:0] mapped_ff, mapped_in;
   logic             hit_ff, hit_in;

   logic [CNT_W-1:0] idx_full;
   logic             issue;
   logic [POS_W-1:0] s_val, e_val;
   logic [POS_W-1:0] len;
   logic [POS_W-1:0] op_a, op_b, diff;
   logic             dec_one, add_en;
   logic             inside_exon, beyond;
   logic [POS_W-1:0] top_val, rel;
   logic             in_window;
   logic             finish;

   assign idx_full = reverse_ff ? (count_ff - ik_ff - CNT_W'(1)) : ik_ff;
   assign rd_addr  = idx_full[IDX_W-1:0];
   assign issue    = (state_ff == WS_RUN) && (ik_ff != count_ff);
   assign finish   = (state_ff == WS_RUN) && (ik_ff == count_ff) && !pv_ff;

   assign s_val = rd_data[ENTRY_W-1:POS_W];
   assign e_val = rd_data[POS_W-1:0];
   assign len   = e_val - s_val;

   // contig to coding terms
   assign inside_exon = (pos_ff >= s_val) && (pos_ff < e_val);
   assign beyond      = reverse_ff ? (pos_ff < s_val) : (pos_ff >= e_val);

   always_comb begin
      op_a    = e_val;
      op_b    = s_val;
      dec_one = 1'b0;
      if (inside_exon && !reverse_ff) begin
         op_a = pos_ff;
      end else if (inside_exon) begin
         op_b    = pos_ff;
         dec_one = 1'b1;
      end
   end

   assign diff   = op_a - op_b - POS_W'(dec_one);
   assign add_en = inside_exon || beyond;

   // coding to contig terms
   assign top_val   = acc_ff + len;
   assign in_window = (pos_ff >= acc_ff) && (pos_ff < top_val);
   assign rel       = pos_ff - acc_ff;

   always_comb begin
      state_in     = state_ff;
      pv_in        = pv_ff;
      ik_in        = ik_ff;
      count_in     = count_ff;
      to_coding_in = to_coding_ff;
      reverse_in   = reverse_ff;
      pos_in       = pos_ff;
      acc_in       = acc_ff;
      total_in     = total_ff;
      mapped_in    = mapped_ff;
      hit_in       = hit_ff;
      case (state_ff)
         WS_IDLE: begin
            pv_in = 1'b0;
            if (cmd.go) begin
               state_in     = WS_RUN;
               ik_in        = '0;
               count_in     = cmd.count;
               to_coding_in = cmd.to_coding;
               reverse_in   = cmd.reverse;
               pos_in       = cmd.position;
               acc_in       = '0;
               total_in     = '0;
               mapped_in    = '0;
               hit_in       = 1'b0;
            end
         end
         WS_RUN: begin
            pv_in = issue;
            if (issue) begin
               ik_in = ik_ff + CNT_W'(1);
            end
            if (pv_ff) begin
               total_in = total_ff + len;
               if (to_coding_ff) begin
                  if (add_en) begin
                     acc_in = acc_ff + diff;
                  end
                  hit_in = hit_ff || inside_exon;
               end else begin
                  acc_in = top_val;
                  if (in_window && !hit_ff) begin
                     hit_in    = 1'b1;
                     mapped_in = reverse_ff ? ((e_val - POS_W'(1)) - rel) : (s_val + rel);
                  end
               end
            end
            if (finish) begin
               state_in = WS_IDLE;
            end
         end
         default: begin
            state_in = WS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= WS_IDLE;
         pv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         pv_ff    <= pv_in;
      end
      ik_ff        <= ik_in;
      count_ff     <= count_in;
      to_coding_ff <= to_coding_in;
      reverse_ff   <= reverse_in;
      pos_ff       <= pos_in;
      acc_ff       <= acc_in;
      total_ff     <= total_in;
      mapped_ff    <= mapped_in;
      hit_ff       <= hit_in;
   end

   assign busy          = (state_ff != WS_IDLE);
   assign result.done   = finish;
   assign result.found  = hit_ff;
   assign result.mapped = !hit_ff ? '0 : (to_coding_ff ? acc_ff : mapped_ff);
   assign result.total  = hit_ff ? total_ff : '0;

endmodule

// File: src/exon_offset_translator_unit.sv
// ----------------------------------------------------------------------------
// exon_offset_translator_unit
// Exon interval table with contig to coding and coding to contig translation.
// ----------------------------------------------------------------------------
// clear, append and a query on an empty table: result registered, valid in the cycle after start
// query on N stored exons: busy while the walk reads the table, result registered after the walk ends
// the walk reads one interval per cycle from the single read port of the table
// one item at a time; results are one-cycle strobes that the receiver cannot stall
// reset empties the table and selects the forward strand; no clearing pass
module exon_offset_translator_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [1:0]                req_opcode,
   input  logic [eot_pkg::POS_W-1:0] req_exon_start,
   input  logic [eot_pkg::POS_W-1:0] req_exon_stop,
   input  logic [eot_pkg::POS_W-1:0] req_query_position,
   output logic                      rsp_valid,
   output logic                      rsp_found,
   output logic [eot_pkg::POS_W-1:0] rsp_mapped_position,
   output logic [eot_pkg::POS_W-1:0] rsp_total_coding_length,
   output logic [1:0]                rsp_status,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic                      csr_strand_reverse
);

   import eot_pkg::*;

   logic             strand_ff, strand_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [POS_W-1:0] last_start_ff, last_start_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_found_ff, rsp_found_in;
   logic [POS_W-1:0] rsp_mapped_ff, rsp_mapped_in;
   logic [POS_W-1:0] rsp_total_ff, rsp_total_in;
   status_type       rsp_status_ff, rsp_status_in;

   logic             accept;
   op_type           op;
   logic             wr_en;
   logic [IDX_W-1:0] rd_addr;
   logic [ENTRY_W-1:0] rd_data;
   logic             walk_busy;
   walk_cmd_type     walk_cmd;
   walk_result_type  walk_res;

   assign accept    = start && !busy;
   assign op        = op_type'(req_opcode);
   assign csr_ready = 1'b1;

   eot_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_EXONS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data ({req_exon_start, req_exon_stop}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign walk_cmd.go        = accept && (op == OP_TO_CODING || op == OP_TO_CONTIG)
                               && (count_ff != '0);
   assign walk_cmd.to_coding = (op == OP_TO_CODING);
   assign walk_cmd.reverse   = strand_ff;
   assign walk_cmd.position  = req_query_position;
   assign walk_cmd.count     = count_ff;

   eot_walk u_walk (
      .clock   (clock),
      .reset   (reset),
      .cmd     (walk_cmd),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .busy    (walk_busy),
      .result  (walk_res)
   );

   always_comb begin
      strand_in     = csr_valid ? csr_strand_reverse : strand_ff;
      count_in      = count_ff;
      last_start_in = last_start_ff;
      wr_en         = 1'b0;
      rsp_valid_in  = 1'b0;
      rsp_found_in  = 1'b0;
      rsp_mapped_in = '0;
      rsp_total_in  = '0;
      rsp_status_in = ST_OK;
      if (walk_res.done) begin
         rsp_valid_in  = 1'b1;
         rsp_found_in  = walk_res.found;
         rsp_mapped_in = walk_res.mapped;
         rsp_total_in  = walk_res.total;
      end else if (accept) begin
         case (op)
            OP_CLEAR: begin
               rsp_valid_in = 1'b1;
               count_in     = '0;
            end
            OP_APPEND: begin
               rsp_valid_in = 1'b1;
               if (count_ff == CNT_W'(MAX_EXONS)) begin
                  rsp_status_in = ST_FULL;
               end else if (count_ff != '0 && req_exon_start <= last_start_ff) begin
                  rsp_status_in = ST_ORDER;
               end else begin
                  wr_en         = 1'b1;
                  count_in      = count_ff + CNT_W'(1);
                  last_start_in = req_exon_start;
               end
            end
            OP_TO_CODING, OP_TO_CONTIG: begin
               if (count_ff == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_EMPTY;
               end
            end
            default: begin
               rsp_valid_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strand_ff    <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         strand_ff    <= strand_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      last_start_ff <= last_start_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_mapped_ff <= rsp_mapped_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy                    = walk_busy;
   assign rsp_valid               = rsp_valid_ff;
   assign rsp_found               = rsp_found_ff;
   assign rsp_mapped_position     = rsp_mapped_ff;
   assign rsp_total_coding_length = rsp_total_ff;
   assign rsp_status              = rsp_status_ff;

   a_busy_no_rsp : assert property (@(posedge clock) disable iff (reset)
      busy |-> !rsp_valid)
      else $error("result strobe while a query walk is running");

   a_item_answered : assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_valid || busy))
      else $error("accepted item neither answered nor walking");

   a_count_range : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_EXONS))
      else $error("exon count beyond table depth");

   a_done_in_walk : assert property (@(posedge clock) disable iff (reset)
      walk_res.done |-> (busy && !accept))
      else $error("walk finished outside a running query");

endmodule

// File: verif/exon_offset_checker.sv
// ----------------------------------------------------------------------------
// exon_offset_checker
// Watches the item, result and strand register channels of the exon offset
// translator. It keeps its own exon table and strand setting, works out the
// result of every accepted item, and compares each result strobe field by
// field with the oldest expected result. It reports the mismatch count, the
// number of results still pending and the number of translations found.
// ----------------------------------------------------------------------------
module exon_offset_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      busy,
   input  logic [1:0]                req_opcode,
   input  logic [eot_pkg::POS_W-1:0] req_exon_start,
   input  logic [eot_pkg::POS_W-1:0] req_exon_stop,
   input  logic [eot_pkg::POS_W-1:0] req_query_position,
   input  logic                      rsp_valid,
   input  logic                      rsp_found,
   input  logic [eot_pkg::POS_W-1:0] rsp_mapped_position,
   input  logic [eot_pkg::POS_W-1:0] rsp_total_coding_length,
   input  logic [1:0]                rsp_status,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic                      csr_strand_reverse,
   output int                        mismatches,
   output int                        outstanding,
   output int                        hits
);
   import eot_pkg::*;

   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] mapped;
      logic [POS_W-1:0] total;
      status_type       status;
   } xlat_type;

   logic [POS_W-1:0] exon_lo [MAX_EXONS];
   logic [POS_W-1:0] exon_hi [MAX_EXONS];
   int unsigned      exon_count;
   logic             reverse_strand;
   xlat_type         pending_q [$];

   function automatic xlat_type translate_item(op_type op, logic [POS_W-1:0] lo,
                                               logic [POS_W-1:0] hi,
                                               logic [POS_W-1:0] pos);
      xlat_type         r;
      logic [POS_W-1:0] acc;
      logic [POS_W-1:0] seg_end;
      logic [POS_W-1:0] s;
      logic [POS_W-1:0] e;
      int               idx;
      logic             hit;
      r = '0;
      case (op)
         OP_CLEAR: begin
            exon_count = 0;
         end
         OP_APPEND: begin
            if (exon_count >= MAX_EXONS) begin
               r.status = ST_FULL;
            end else if (exon_count > 0 && lo <= exon_lo[exon_count-1]) begin
               r.status = ST_ORDER;
            end else begin
               exon_lo[exon_count] = lo;
               exon_hi[exon_count] = hi;
               exon_count++;
            end
         end
         default: begin
            if (exon_count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               acc = '0;
               hit = 1'b0;
               for (int k = 0; k < exon_count; k++) begin
                  idx = reverse_strand ? exon_count - 1 - k : k;
                  s = exon_lo[idx];
                  e = exon_hi[idx];
                  if (op == OP_TO_CODING) begin
                     // overlapping exons each add their share
                     if (pos >= s && pos < e) begin
                        acc = acc + (reverse_strand ? e - pos - 1 : pos - s);
                        hit = 1'b1;
                     end else if (reverse_strand ? pos < s : pos >= e) begin
                        acc = acc + (e - s);
                     end
                  end else if (!hit) begin
                     // first exon in walk order whose window holds the offset
                     seg_end = acc + (e - s);
                     if (pos >= acc && pos < seg_end) begin
                        r.mapped = reverse_strand ? e - 1 - (pos - acc) : s + (pos - acc);
                        hit = 1'b1;
                     end else begin
                        acc = seg_end;
                     end
                  end
               end
               if (hit) begin
                  r.found = 1'b1;
                  if (op == OP_TO_CODING) begin
                     r.mapped = acc;
                  end
                  for (int k = 0; k < exon_count; k++) begin
                     r.total = r.total + (exon_hi[k] - exon_lo[k]);
                  end
               end
            end
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin : watch
      xlat_type want;
      int       bad;
      bad = 0;
      if (reset) begin
         exon_count     = 0;
         reverse_strand = 1'b0;
         pending_q.delete();
         mismatches  <= 0;
         hits        <= 0;
         outstanding <= 0;
      end else begin
         if (rsp_valid) begin
            if (pending_q.size() == 0) begin
               $error("result strobe with no item pending");
               bad++;
            end else begin
               want = pending_q.pop_front();
               if (rsp_found !== want.found) begin
                  $error("found: expected %0d, actual %0d", want.found, rsp_found);
                  bad++;
               end
               if (rsp_mapped_position !== want.mapped) begin
                  $error("mapped_position: expected %0h, actual %0h",
                         want.mapped, rsp_mapped_position);
                  bad++;
               end
               if (rsp_total_coding_length !== want.total) begin
                  $error("total_coding_length: expected %0h, actual %0h",
                         want.total, rsp_total_coding_length);
                  bad++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_status);
                  bad++;
               end
               hits <= hits + want.found;
            end
         end
         if (csr_valid && csr_ready) begin
            reverse_strand = csr_strand_reverse;
         end
         if (start && !busy) begin
            pending_q = {pending_q, translate_item(op_type'(req_opcode), req_exon_start,
                                                   req_exon_stop, req_query_position)};
         end
         mismatches  <= mismatches + bad;
         outstanding <= pending_q.size();
      end
   end

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the exon offset translator unit. A short directed
// run covers empty-table queries, rejected and wrapping appends, hits, misses
// and both strands. Random exon tables follow, most of them well formed with
// queries aimed at exon edges and coding offset limits, some filled to full
// depth, mixed with raw random items and strand changes between phases.
// ----------------------------------------------------------------------------
module tb;
   import eot_pkg::*;

   localparam int ITEM_GOAL      = 1900;
   localparam int WATCHDOG_LIMIT = 2000;

   logic             clock;
   logic             reset              = 1'b1;
   logic             start              = 1'b0;
   logic             busy;
   logic [1:0]       req_opcode         = '0;
   logic [POS_W-1:0] req_exon_start     = '0;
   logic [POS_W-1:0] req_exon_stop      = '0;
   logic [POS_W-1:0] req_query_position = '0;
   logic             rsp_valid;
   logic             rsp_found;
   logic [POS_W-1:0] rsp_mapped_position;
   logic [POS_W-1:0] rsp_total_coding_length;
   logic [1:0]       rsp_status;
   logic             csr_valid          = 1'b0;
   logic             csr_ready;
   logic             csr_strand_reverse = 1'b0;

   int               mismatches;
   int               outstanding;
   int               hits;
   int               items_sent    = 0;
   int               strand_writes = 0;
   int               stall_cycles  = 0;
   bit               steady        = 1'b0;
   logic [POS_W-1:0] plan_lo [$];
   logic [POS_W-1:0] plan_hi [$];

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   exon_offset_translator_unit DUT (
      .clock                   (clock),
      .reset                   (reset),
      .start                   (start),
      .busy                    (busy),
      .req_opcode              (req_opcode),
      .req_exon_start          (req_exon_start),
      .req_exon_stop           (req_exon_stop),
      .req_query_position      (req_query_position),
      .rsp_valid               (rsp_valid),
      .rsp_found               (rsp_found),
      .rsp_mapped_position     (rsp_mapped_position),
      .rsp_total_coding_length (rsp_total_coding_length),
      .rsp_status              (rsp_status),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_strand_reverse      (csr_strand_reverse)
   );

   exon_offset_checker u_check (
      .clock                   (clock),
      .reset                   (reset),
      .start                   (start),
      .busy                    (busy),
      .req_opcode              (req_opcode),
      .req_exon_start          (req_exon_start),
      .req_exon_stop           (req_exon_stop),
      .req_query_position      (req_query_position),
      .rsp_valid               (rsp_valid),
      .rsp_found               (rsp_found),
      .rsp_mapped_position     (rsp_mapped_position),
      .rsp_total_coding_length (rsp_total_coding_length),
      .rsp_status              (rsp_status),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_strand_reverse      (csr_strand_reverse),
      .mismatches              (mismatches),
      .outstanding             (outstanding),
      .hits                    (hits)
   );

   task automatic send_item(op_type op, logic [POS_W-1:0] lo, logic [POS_W-1:0] hi,
                            logic [POS_W-1:0] pos);
      int gap;
      int r;
      r = $urandom_range(0, 99);
      gap = (steady || r < 65) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(8, 40);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_opcode         <= op;
      req_exon_start     <= lo;
      req_exon_stop      <= hi;
      req_query_position <= pos;
      start              <= 1'b1;
      do @(posedge clock); while (busy);
      items_sent++;
   endtask

   task automatic settle();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_strand(logic value);
      csr_strand_reverse <= value;
      csr_valid          <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      strand_writes++;
   endtask

   task automatic run_query();
      op_type           op;
      logic [POS_W-1:0] pos;
      logic [POS_W-1:0] tot;
      logic [POS_W-1:0] lo;
      logic [POS_W-1:0] hi;
      int               pick;
      op  = $urandom_range(0, 1) ? OP_TO_CODING : OP_TO_CONTIG;
      pos = $urandom;
      if (plan_lo.size() > 0 && $urandom_range(0, 4) != 0) begin
         if (op == OP_TO_CODING) begin
            pick = $urandom_range(0, plan_lo.size() - 1);
            lo   = plan_lo[pick];
            hi   = plan_hi[pick];
            pos  = lo - 2 + $urandom_range(0, (hi - lo > 100) ? 104 : hi - lo + 3);
         end else begin
            tot = '0;
            foreach (plan_lo[k]) tot = tot + (plan_hi[k] - plan_lo[k]);
            pos = $urandom_range(0, 1) ? $urandom_range(0, (tot > 200) ? 200 : tot + 2)
                                       : tot - 3 + $urandom_range(0, 5);
         end
      end
      send_item(op, $urandom, $urandom, pos);
   endtask

   task automatic run_sequence();
      op_type           op;
      int               n;
      logic [POS_W:0]   next_lo;
      logic [POS_W-1:0] lo;
      logic [POS_W-1:0] hi;
      bit               wrapped;
      if ($urandom_range(0, 99) < 12) begin
         // raw random items
         repeat ($urandom_range(1, 6)) begin
            op = op_type'($urandom_range(0, 3));
            if (op == OP_CLEAR) begin
               plan_lo.delete();
               plan_hi.delete();
            end
            send_item(op, $urandom, $urandom, $urandom);
         end
      end else begin
         send_item(OP_CLEAR, $urandom, $urandom, $urandom);
         plan_lo.delete();
         plan_hi.delete();
         n       = ($urandom_range(0, 24) == 0) ? $urandom_range(62, 67) : $urandom_range(0, 8);
         next_lo = {1'b0, ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1000)};
         wrapped = 1'b0;
         for (int j = 0; j < n && !wrapped; j++) begin
            if (n < 62 && plan_lo.size() > 0 && $urandom_range(0, 11) == 0) begin
               // start at or below the last one
               send_item(OP_APPEND, plan_lo[$] - $urandom_range(0, 3), $urandom, $urandom);
            end else begin
               lo = next_lo[POS_W-1:0];
               case ($urandom_range(0, 9))
                  0:       hi = lo;
                  1:       hi = $urandom;
                  2:       hi = lo + $urandom_range(30, 90);
                  default: hi = lo + $urandom_range(1, 30);
               endcase
               send_item(OP_APPEND, lo, hi, $urandom);
               if (plan_lo.size() < MAX_EXONS) begin
                  plan_lo = {plan_lo, lo};
                  plan_hi = {plan_hi, hi};
               end
               next_lo = next_lo + (POS_W+1)'($urandom_range(1, 40));
               wrapped = next_lo[POS_W];
            end
         end
         repeat ($urandom_range(2, 10)) run_query();
      end
   endtask

   initial begin : stimulus
      int phase;
      int phase_start;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      write_strand(1'b0);

      // empty table, rejected appends, edges and misses on the forward strand
      send_item(OP_TO_CODING, 32'h0, 32'h0, 32'h0);
      send_item(OP_TO_CONTIG, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(OP_CLEAR, 32'h0, 32'h0, 32'h0);
      send_item(OP_APPEND, 32'd100, 32'd110, 32'h0);
      send_item(OP_APPEND, 32'd200, 32'd205, 32'h0);
      send_item(OP_APPEND, 32'd150, 32'd160, 32'h0);
      send_item(OP_APPEND, 32'd200, 32'd300, 32'h0);
      send_item(OP_TO_CODING, 32'h0, 32'h0, 32'd100);
      send_item(OP_TO_CODING, 32'h0, 32'h0, 32'd109);
      send_item(OP_TO_CODING, 32'h0, 32'h0, 32'd110);
      send_item(OP_TO_CODING, 32'h0, 32'h0, 32'd204);
      send_item(OP_TO_CODING, 32'h0, 32'h0, 32'hFFFF_FFFF);
      send_item(OP_TO_CONTIG, 32'h0, 32'h0, 32'd0);
      send_item(OP_TO_CONTIG, 32'h0, 32'h0, 32'd14);
      send_item(OP_TO_CONTIG, 32'h0, 32'h0, 32'd15);
      send_item(OP_APPEND, 32'hFFFF_FFF0, 32'h0000_0010, 32'h0);
      send_item(OP_APPEND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
      send_item(OP_TO_CODING, 32'h0, 32'h0, 32'hFFFF_FFF5);
      send_item(OP_TO_CONTIG, 32'h0, 32'h0, 32'd20);

      // same table walked on the reverse strand, then cleared and queried empty
      settle();
      write_strand(1'b1);
      send_item(OP_TO_CODING, 32'h0, 32'h0, 32'd100);
      send_item(OP_TO_CODING, 32'h0, 32'h0, 32'd204);
      send_item(OP_TO_CONTIG, 32'h0, 32'h0, 32'd0);
      send_item(OP_TO_CONTIG, 32'h0, 32'h0, 32'd14);
      send_item(OP_TO_CONTIG, 32'h0, 32'h0, 32'd40);
      send_item(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(OP_TO_CONTIG, 32'h0, 32'h0, 32'd0);

      phase = 0;
      while (items_sent < ITEM_GOAL) begin
         settle();
         write_strand((phase % 4 == 0) ? 1'b0 : (phase % 4 == 1) ? 1'b1 : 1'($urandom));
         steady      = ($urandom_range(0, 4) == 0);
         phase_start = items_sent;
         while (items_sent - phase_start < 150 && items_sent < ITEM_GOAL) begin
            run_sequence();
         end
         phase++;
      end

      settle();
      repeat (30) @(posedge clock);
      $display("covered %0d items, %0d translations found, %0d strand writes",
               items_sent, hits, strand_writes);
      $display("tables from empty to full depth, rejected and wrapping exons, both strands");
      if (mismatches == 0 && outstanding == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles == WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

endmodule
